// ===== rtl/cdu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the donor-cell u convection core.
// No dependencies; every other rtl file refers to this package by scoped names.
package cdu_pkg;

	localparam int WordBits   = 32;
	localparam int FracBits   = 16;
	localparam int RecipBits  = 32;
	localparam int GammaBits  = 16;
	localparam int GammaWidth = GammaBits + 1;
	localparam int ProdBits   = WordBits + RecipBits + 2;
	localparam int CfgIdxBits = 2;
	localparam int CfgDataBits = 32;

	localparam logic [GammaWidth-1:0] GammaOne   = {1'b1, {GammaBits{1'b0}}};
	localparam logic [GammaWidth-1:0] GammaReset = GammaOne >> 1;
	localparam logic [RecipBits-1:0]  RecipReset = RecipBits'(1) << FracBits;

	typedef logic signed [WordBits-1:0] word_t;
	typedef logic        [WordBits-1:0] mag_t;
	typedef logic signed [ProdBits-1:0] wide_t;
	typedef logic signed [WordBits+RecipBits:0] recip_prod_t;

	localparam word_t WordMax = {1'b0, {(WordBits-1){1'b1}}};
	localparam word_t WordMin = {1'b1, {(WordBits-1){1'b0}}};

	typedef enum logic [CfgIdxBits-1:0] {
		RegRecipDx,
		RegRecipDy,
		RegGamma
	} cfg_reg_e;

	typedef struct packed {
		logic [RecipBits-1:0]  recip_dx;
		logic [RecipBits-1:0]  recip_dy;
		logic [GammaWidth-1:0] gamma;
	} cfg_t;

	typedef struct packed {
		logic  sat;
		word_t val;
	} sat_word_t;

	// Face operands of one direction: central pair, upwind pair on each side
	typedef struct packed {
		word_t fa_p;
		word_t fb_p;
		word_t fa_m;
		word_t fb_m;
		mag_t  fv_p;
		word_t hd_p;
		mag_t  fv_m;
		word_t hd_m;
	} flux_in_t;

	typedef struct packed {
		logic  sat;
		word_t central;
		word_t upwind;
	} flux_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

	// floor((a + b) / 2)
	function automatic word_t avg2(word_t a, word_t b);
		logic [WordBits:0] sum;
		sum = {a[WordBits-1], a} + {b[WordBits-1], b};
		return sum[WordBits:1];
	endfunction

	// floor((a - b) / 2)
	function automatic word_t hdiff2(word_t a, word_t b);
		logic [WordBits:0] diff;
		diff = {a[WordBits-1], a} - {b[WordBits-1], b};
		return diff[WordBits:1];
	endfunction

	function automatic mag_t mag(word_t a);
		return a[WordBits-1] ? mag_t'(~a + 1'b1) : mag_t'(a);
	endfunction

	function automatic sat_word_t clip(wide_t x);
		sat_word_t r;
		if (x[ProdBits-1:WordBits-1] != {(ProdBits-WordBits+1){x[ProdBits-1]}}) begin
			r.sat = 1'b1;
			r.val = x[ProdBits-1] ? WordMin : WordMax;
		end else begin
			r.sat = 1'b0;
			r.val = x[WordBits-1:0];
		end
		return r;
	endfunction

	function automatic sat_word_t add_sat(word_t a, word_t b);
		logic [WordBits:0] s;
		sat_word_t r;
		s = {a[WordBits-1], a} + {b[WordBits-1], b};
		r.sat = s[WordBits] != s[WordBits-1];
		r.val = r.sat ? (s[WordBits] ? WordMin : WordMax) : s[WordBits-1:0];
		return r;
	endfunction

	function automatic sat_word_t sub_sat(word_t a, word_t b);
		logic [WordBits:0] s;
		sat_word_t r;
		s = {a[WordBits-1], a} - {b[WordBits-1], b};
		r.sat = s[WordBits] != s[WordBits-1];
		r.val = r.sat ? (s[WordBits] ? WordMin : WordMax) : s[WordBits-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/cdu_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file: 1/dx, 1/dy and the upwind blend factor.
// Depends on cdu_pkg.
module cdu_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cdu_pkg::CfgIdxBits-1:0]       cfg_index,
	input  logic [cdu_pkg::CfgDataBits-1:0]      cfg_data,
	output cdu_pkg::cfg_t                        cfg
);

	logic [cdu_pkg::RecipBits-1:0]  recip_dx_q;
	logic [cdu_pkg::RecipBits-1:0]  recip_dy_q;
	logic [cdu_pkg::GammaWidth-1:0] gamma_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_dx_q <= cdu_pkg::RecipReset;
			recip_dy_q <= cdu_pkg::RecipReset;
			gamma_q    <= cdu_pkg::GammaReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cdu_pkg::cfg_reg_e'(cfg_index))
				cdu_pkg::RegRecipDx: recip_dx_q <= cfg_data[cdu_pkg::RecipBits-1:0];
				cdu_pkg::RegRecipDy: recip_dy_q <= cfg_data[cdu_pkg::RecipBits-1:0];
				cdu_pkg::RegGamma:   gamma_q    <= cfg_data[cdu_pkg::GammaWidth-1:0];
				default: ;
			endcase
		end
	end

	// gamma above one acts as one
	always_comb begin
		cfg.recip_dx = recip_dx_q;
		cfg.recip_dy = recip_dy_q;
		cfg.gamma    = (gamma_q > cdu_pkg::GammaOne) ? cdu_pkg::GammaOne : gamma_q;
	end

endmodule

// ===== rtl/cdu_stencil.sv =====
`timescale 1ns / 1ps
// Stage 1: face averages, half differences and face speed magnitudes of the stencil.
// Depends on cdu_pkg.
module cdu_stencil (
	input  logic                clk,
	input  cdu_pkg::stage_en_t  en,
	input  cdu_pkg::word_t      u_center,
	input  cdu_pkg::word_t      u_east,
	input  cdu_pkg::word_t      u_west,
	input  cdu_pkg::word_t      u_north,
	input  cdu_pkg::word_t      u_south,
	input  cdu_pkg::word_t      v_center,
	input  cdu_pkg::word_t      v_east,
	input  cdu_pkg::word_t      v_south,
	input  cdu_pkg::word_t      v_southeast,
	output cdu_pkg::flux_in_t   x_s1,
	output cdu_pkg::flux_in_t   y_s1
);

	cdu_pkg::word_t fe, fw, gn, gs, an, a_s;
	cdu_pkg::flux_in_t x_d, y_d;

	always_comb begin
		fe  = cdu_pkg::avg2(u_center, u_east);
		fw  = cdu_pkg::avg2(u_west, u_center);
		gn  = cdu_pkg::avg2(v_center, v_east);
		gs  = cdu_pkg::avg2(v_south, v_southeast);
		an  = cdu_pkg::avg2(u_center, u_north);
		a_s = cdu_pkg::avg2(u_south, u_center);

		x_d.fa_p = fe;
		x_d.fb_p = fe;
		x_d.fa_m = fw;
		x_d.fb_m = fw;
		x_d.fv_p = cdu_pkg::mag(fe);
		x_d.hd_p = cdu_pkg::hdiff2(u_center, u_east);
		x_d.fv_m = cdu_pkg::mag(fw);
		x_d.hd_m = cdu_pkg::hdiff2(u_west, u_center);

		y_d.fa_p = gn;
		y_d.fb_p = an;
		y_d.fa_m = gs;
		y_d.fb_m = a_s;
		y_d.fv_p = cdu_pkg::mag(gn);
		y_d.hd_p = cdu_pkg::hdiff2(u_center, u_north);
		y_d.fv_m = cdu_pkg::mag(gs);
		y_d.hd_m = cdu_pkg::hdiff2(u_south, u_center);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			x_s1 <= x_d;
			y_s1 <= y_d;
		end
	end

endmodule

// ===== rtl/cdu_flux.sv =====
`timescale 1ns / 1ps
// Stages 2-3 of one direction: four face products, then clip and form central and upwind parts.
// Depends on cdu_pkg.
module cdu_flux (
	input  logic                clk,
	input  cdu_pkg::stage_en_t  en,
	input  cdu_pkg::flux_in_t   d_s1,
	output cdu_pkg::flux_t      flux_s3
);

	localparam int W = cdu_pkg::WordBits;

	logic signed [2*W-1:0] cp_s2, cm_s2;
	logic signed [2*W:0]   up_s2, um_s2;

	cdu_pkg::sat_word_t cp, cm, up, um, central, upwind;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			cp_s2 <= $signed(d_s1.fa_p) * $signed(d_s1.fb_p);
			cm_s2 <= $signed(d_s1.fa_m) * $signed(d_s1.fb_m);
			up_s2 <= $signed({1'b0, d_s1.fv_p}) * $signed(d_s1.hd_p);
			um_s2 <= $signed({1'b0, d_s1.fv_m}) * $signed(d_s1.hd_m);
		end
	end

	// arithmetic shift floors the product toward minus infinity
	always_comb begin
		cp      = cdu_pkg::clip(cdu_pkg::wide_t'(cp_s2 >>> cdu_pkg::FracBits));
		cm      = cdu_pkg::clip(cdu_pkg::wide_t'(cm_s2 >>> cdu_pkg::FracBits));
		up      = cdu_pkg::clip(cdu_pkg::wide_t'(up_s2 >>> cdu_pkg::FracBits));
		um      = cdu_pkg::clip(cdu_pkg::wide_t'(um_s2 >>> cdu_pkg::FracBits));
		central = cdu_pkg::sub_sat(cp.val, cm.val);
		upwind  = cdu_pkg::sub_sat(up.val, um.val);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			flux_s3.central <= central.val;
			flux_s3.upwind  <= upwind.val;
			flux_s3.sat     <= cp.sat | cm.sat | up.sat | um.sat | central.sat | upwind.sat;
		end
	end

endmodule

// ===== rtl/cdu_dir.sv =====
`timescale 1ns / 1ps
// Stages 4-6 of one direction: weight the upwind part, add the central part, scale by 1/h.
// Depends on cdu_pkg.
module cdu_dir (
	input  logic                                  clk,
	input  cdu_pkg::stage_en_t                    en,
	input  cdu_pkg::flux_t                        flux_s3,
	input  logic [cdu_pkg::RecipBits-1:0]         recip,
	input  logic [cdu_pkg::GammaWidth-1:0]        gamma,
	output cdu_pkg::recip_prod_t                  prod_s6,
	output logic                                  sat_s6
);

	localparam int W = cdu_pkg::WordBits;

	logic signed [W+cdu_pkg::GammaWidth:0] gp_s4;
	cdu_pkg::word_t central_s4;
	logic           sat_s4;
	cdu_pkg::word_t sum_s5;
	logic           sat_s5;

	cdu_pkg::sat_word_t wt, sum;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			gp_s4      <= $signed(flux_s3.upwind) * $signed({1'b0, gamma});
			central_s4 <= flux_s3.central;
			sat_s4     <= flux_s3.sat;
		end
	end

	always_comb begin
		wt  = cdu_pkg::clip(cdu_pkg::wide_t'(gp_s4 >>> cdu_pkg::GammaBits));
		sum = cdu_pkg::add_sat(central_s4, wt.val);
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			sum_s5 <= sum.val;
			sat_s5 <= sat_s4 | wt.sat | sum.sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			prod_s6 <= $signed(sum_s5) * $signed({1'b0, recip});
			sat_s6  <= sat_s5;
		end
	end

endmodule

// ===== rtl/donor_cell_convection_u_core.sv =====
`timescale 1ns / 1ps
// Top level of the donor-cell convection core for u momentum: pipeline control and final sum.
// Depends on cdu_pkg, cdu_cfg, cdu_stencil, cdu_flux and cdu_dir.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one nine-value stencil per beat; a beat is
//   taken at a rising edge with in_valid high and in_stall low. Output channel
//   (out_valid / out_stall) returns conv_term = d(u^2)/dx + d(uv)/dy in signed Q16.16 and a
//   saturated flag set when any intermediate or the final sum was clipped.
//   Seven register stages: face averages, face products, central/upwind parts, gamma
//   product, blend sum, 1/h product, final sum in the output register. Throughput is one
//   beat per cycle unless the output stalls; every stage holds one item and advances on its
//   own enable, so bubbles close up while the output waits. in_stall rises only when all
//   seven stages are full and out_stall is high; nothing is dropped or repeated under stall.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) writes 1/dx (index 0),
//   1/dy (1) and gamma (2, Q1.16, values above one act as one). cfg_ready is always high;
//   write only while the pipeline is empty. Other indexes are ignored.
//   Reset (arst_n low) empties the pipeline and sets 1/dx = 1/dy = 1.0, gamma = 0.5.
module donor_cell_convection_u_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cdu_pkg::CfgIdxBits-1:0]     cfg_index,
	input  logic [cdu_pkg::CfgDataBits-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [cdu_pkg::WordBits-1:0] u_center,
	input  logic signed [cdu_pkg::WordBits-1:0] u_east,
	input  logic signed [cdu_pkg::WordBits-1:0] u_west,
	input  logic signed [cdu_pkg::WordBits-1:0] u_north,
	input  logic signed [cdu_pkg::WordBits-1:0] u_south,
	input  logic signed [cdu_pkg::WordBits-1:0] v_center,
	input  logic signed [cdu_pkg::WordBits-1:0] v_east,
	input  logic signed [cdu_pkg::WordBits-1:0] v_south,
	input  logic signed [cdu_pkg::WordBits-1:0] v_southeast,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [cdu_pkg::WordBits-1:0] conv_term,
	output logic                               saturated
);

	cdu_pkg::cfg_t       cfg;
	cdu_pkg::stage_en_t  en;
	cdu_pkg::flux_in_t   x_s1, y_s1;
	cdu_pkg::flux_t      xf_s3, yf_s3;
	cdu_pkg::recip_prod_t xp_s6, yp_s6;
	logic                xsat_s6, ysat_s6;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	cdu_pkg::word_t conv_s7;
	logic           sat_s7;

	cdu_pkg::sat_word_t tx, ty, total;

	// a stage takes a new item when empty or when its content moves on
	always_comb begin
		en.s7 = !v_s7 || !out_stall;
		en.s6 = !v_s6 || en.s7;
		en.s5 = !v_s5 || en.s6;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_stall = !en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
			if (en.s7) v_s7 <= v_s6;
		end
	end

	cdu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cdu_stencil u_stencil (
		.clk         (clk),
		.en          (en),
		.u_center    (u_center),
		.u_east      (u_east),
		.u_west      (u_west),
		.u_north     (u_north),
		.u_south     (u_south),
		.v_center    (v_center),
		.v_east      (v_east),
		.v_south     (v_south),
		.v_southeast (v_southeast),
		.x_s1        (x_s1),
		.y_s1        (y_s1)
	);

	cdu_flux u_flux_x (
		.clk     (clk),
		.en      (en),
		.d_s1    (x_s1),
		.flux_s3 (xf_s3)
	);

	cdu_flux u_flux_y (
		.clk     (clk),
		.en      (en),
		.d_s1    (y_s1),
		.flux_s3 (yf_s3)
	);

	cdu_dir u_dir_x (
		.clk     (clk),
		.en      (en),
		.flux_s3 (xf_s3),
		.recip   (cfg.recip_dx),
		.gamma   (cfg.gamma),
		.prod_s6 (xp_s6),
		.sat_s6  (xsat_s6)
	);

	cdu_dir u_dir_y (
		.clk     (clk),
		.en      (en),
		.flux_s3 (yf_s3),
		.recip   (cfg.recip_dy),
		.gamma   (cfg.gamma),
		.prod_s6 (yp_s6),
		.sat_s6  (ysat_s6)
	);

	always_comb begin
		tx    = cdu_pkg::clip(cdu_pkg::wide_t'(xp_s6 >>> cdu_pkg::FracBits));
		ty    = cdu_pkg::clip(cdu_pkg::wide_t'(yp_s6 >>> cdu_pkg::FracBits));
		total = cdu_pkg::add_sat(tx.val, ty.val);
	end

	always_ff @(posedge clk) begin
		if (en.s7) begin
			conv_s7 <= total.val;
			sat_s7  <= xsat_s6 | ysat_s6 | tx.sat | ty.sat | total.sat;
		end
	end

	assign out_valid = v_s7;
	assign conv_term = conv_s7;
	assign saturated = sat_s7;

	// upstream is held off only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7))
		else $error("input stalled with an empty stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> v_s1)
		else $error("accepted beat missing from stage 1");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !out_stall) |=> out_valid)
		else $error("item lost between stage 6 and output");

endmodule
